/* sv/owned_mutex_with_wait_queue_macros.svh */
// Assertion macros for the owned mutex block and its checker.
// Depends on nothing; the including module supplies clk and rst.
`ifndef OWNED_MUTEX_WITH_WAIT_QUEUE_MACROS_SVH
`define OWNED_MUTEX_WITH_WAIT_QUEUE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define OMWQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("omwq assertion failed");

// Check a property on every clock edge, reset included.
`define OMWQ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("omwq assertion failed");

`endif

/* sv/omwq_pkg.sv */
// Shared constants and codes for the owned mutex with wait queue.
// Used by the top level and by its assertion checker; depends on nothing.
`default_nettype none

package omwq_pkg;

  localparam int WAIT_DEPTH = 8;
  localparam int CNT_W      = $clog2(WAIT_DEPTH + 1);
  localparam int IDX_W      = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int WCNT_W     = (CNT_W > 4) ? CNT_W : 4;

  localparam int REQ_W   = 2;
  localparam int TASK_W  = 16;
  localparam int THR_W   = 8;
  localparam int ORDER_W = 8;
  localparam int STAT_W  = 3;
  localparam int WAITERS_W = 4;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  // Bit offsets of the result fields in m_tdata.
  localparam int OFS_STATUS  = 0;
  localparam int OFS_WARN    = 3;
  localparam int OFS_WVALID  = 4;
  localparam int OFS_WTASK   = 5;
  localparam int OFS_WTHR    = 21;
  localparam int OFS_NEWMAX  = 29;
  localparam int OFS_LOCKED  = 37;
  localparam int OFS_WAITERS = 38;
  localparam int OUT_USED_W  = 42;

  localparam logic [REQ_W-1:0] REQ_LOCK    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_UNLOCK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TRYLOCK = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_ACQUIRED      = 3'd0,
    ST_QUEUED        = 3'd1,
    ST_QUEUE_FULL    = 3'd2,
    ST_SELF_DEADLOCK = 3'd3,
    ST_RELEASED      = 3'd4,
    ST_NOT_LOCKED    = 3'd5,
    ST_NOT_OWNER     = 3'd6,
    ST_TRY_BUSY      = 3'd7
  } status_t;

endpackage

`default_nettype wire

/* sv/owned_mutex_with_wait_queue.sv */
// Owned hardware mutex with a FIFO wait queue, stream in and stream out.
// Depends on omwq_pkg for widths, request codes and status codes.
`default_nettype none

// A request word passes the input register, then the result register (m_tdata).
// Throughput: one request per cycle unless the output stalls; from the input register,
//   one pass of compare and queue logic updates mutex state and the result register.
// Reset (rst, synchronous): mutex free, holder cleared, no waiters, rank 0,
//   both stages empty. Queue entries are not cleared; only entries below the
//   waiter count are ever read.
module owned_mutex_with_wait_queue (
  input  wire                                   clk,
  input  wire                                   rst,
  // configuration: mutex rank, zero disables order checks
  input  wire                                   rank_we,
  input  wire  [omwq_pkg::ORDER_W-1:0]          rank_wdata,
  // request words
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  // task_id [15:0], thread_id [23:16], max_order_held [31:24]
  input  wire  [omwq_pkg::IN_DATA_W-1:0]        s_tdata,
  // req_type [1:0]
  input  wire  [omwq_pkg::REQ_W-1:0]            s_tuser,
  // result words
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  // status [2:0], order_warning [3], woken_valid [4], woken_task [20:5],
  // woken_thread [28:21], new_max_order [36:29], is_locked [37],
  // waiters_now [41:38], zero [47:42]
  output logic [omwq_pkg::OUT_DATA_W-1:0]       m_tdata
);
  import omwq_pkg::*;

  // Configuration register.
  logic [ORDER_W-1:0] mutex_rank;

  // Input register stage.
  logic               in_vld;
  logic [REQ_W-1:0]   in_req;
  logic [TASK_W-1:0]  in_task;
  logic [THR_W-1:0]   in_thread;
  logic [ORDER_W-1:0] in_maxh;

  // Mutex state.
  logic               held;
  logic [TASK_W-1:0]  holder_task;
  logic [THR_W-1:0]   holder_thread;
  logic [CNT_W-1:0]   waiter_count;
  logic [TASK_W-1:0]  queued_tasks   [WAIT_DEPTH];
  logic [THR_W-1:0]   queued_threads [WAIT_DEPTH];

  // Output register stage.
  logic               out_vld;
  logic [OUT_DATA_W-1:0] out_data;
  logic [OUT_DATA_W-1:0] result_word;

  // Per-request decisions.
  logic               advance;
  logic               is_owner;
  logic               order_hit;
  logic [ORDER_W-1:0] acq_max;
  status_t            status;
  logic               warn;
  logic [ORDER_W-1:0] new_max;
  logic               held_next;
  logic [TASK_W-1:0]  holder_task_next;
  logic [THR_W-1:0]   holder_thread_next;
  logic               push;
  logic               pop;
  logic [CNT_W-1:0]   waiter_count_next;
  logic [TASK_W-1:0]  woken_task;
  logic [THR_W-1:0]   woken_thread;
  logic [WCNT_W-1:0]  waiters_wide;
  logic [IDX_W-1:0]   tail_idx;

  // Move the input word on when the result register is free or being drained.
  assign advance  = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || advance;
  assign m_tvalid = out_vld;
  assign m_tdata  = out_data;

  assign is_owner  = held && (holder_task == in_task) && (holder_thread == in_thread);
  assign order_hit = (mutex_rank != '0) && (in_maxh >= mutex_rank);
  assign acq_max   = (in_maxh > mutex_rank) ? in_maxh : mutex_rank;
  assign tail_idx  = waiter_count[IDX_W-1:0];

  always_comb begin
    status             = ST_TRY_BUSY;
    warn               = 1'b0;
    new_max            = in_maxh;
    held_next          = held;
    holder_task_next   = holder_task;
    holder_thread_next = holder_thread;
    push               = 1'b0;
    pop                = 1'b0;
    case (in_req)
      REQ_LOCK: begin
        if (is_owner) begin
          // Owner locking again: report and leave everything alone.
          status = ST_SELF_DEADLOCK;
        end else begin
          warn = order_hit;
          if (held) begin
            if (waiter_count < CNT_W'(WAIT_DEPTH)) begin
              push   = 1'b1;
              status = ST_QUEUED;
            end else begin
              status = ST_QUEUE_FULL;
            end
          end else begin
            held_next          = 1'b1;
            holder_task_next   = in_task;
            holder_thread_next = in_thread;
            new_max            = acq_max;
            status             = ST_ACQUIRED;
          end
        end
      end
      REQ_UNLOCK: begin
        if (!held) begin
          status = ST_NOT_LOCKED;
        end else if (!is_owner) begin
          status = ST_NOT_OWNER;
        end else begin
          held_next          = 1'b0;
          holder_task_next   = '0;
          holder_thread_next = '0;
          // Drop the system maximum when this mutex was the one setting it.
          if ((mutex_rank != '0) && (in_maxh == mutex_rank)) begin
            new_max = '0;
          end
          pop    = (waiter_count != '0);
          status = ST_RELEASED;
        end
      end
      default: begin
        // Trylock, and the unused request code decoded the same way.
        if (!held) begin
          held_next          = 1'b1;
          holder_task_next   = in_task;
          holder_thread_next = in_thread;
          new_max            = acq_max;
          status             = ST_ACQUIRED;
        end
      end
    endcase
  end

  always_comb begin
    waiter_count_next = waiter_count;
    if (push) begin
      waiter_count_next = waiter_count + CNT_W'(1);
    end else if (pop) begin
      waiter_count_next = waiter_count - CNT_W'(1);
    end
  end

  assign woken_task   = pop ? queued_tasks[0]   : '0;
  assign woken_thread = pop ? queued_threads[0] : '0;
  assign waiters_wide = WCNT_W'(waiter_count_next);

  // Pack the result fields, padding bits held at zero.
  always_comb begin
    result_word                              = '0;
    result_word[OFS_STATUS +: STAT_W]        = status;
    result_word[OFS_WARN]                    = warn;
    result_word[OFS_WVALID]                  = pop;
    result_word[OFS_WTASK +: TASK_W]         = woken_task;
    result_word[OFS_WTHR +: THR_W]           = woken_thread;
    result_word[OFS_NEWMAX +: ORDER_W]       = new_max;
    result_word[OFS_LOCKED]                  = held_next;
    result_word[OFS_WAITERS +: WAITERS_W]    = waiters_wide[WAITERS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mutex_rank <= '0;
    end else if (rank_we) begin
      mutex_rank <= rank_wdata;
    end
  end

  // Input register: take a new word whenever the stage is empty or moving on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req    <= s_tuser;
      in_task   <= s_tdata[15:0];
      in_thread <= s_tdata[23:16];
      in_maxh   <= s_tdata[31:24];
    end
  end

  // Mutex state advances once per request, as the request leaves the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      held          <= 1'b0;
      holder_task   <= '0;
      holder_thread <= '0;
      waiter_count  <= '0;
    end else if (advance) begin
      held          <= held_next;
      holder_task   <= holder_task_next;
      holder_thread <= holder_thread_next;
      waiter_count  <= waiter_count_next;
    end
  end

  // Wait queue: push at the tail, pop by shifting every entry toward the head.
  always_ff @(posedge clk) begin
    if (advance && push) begin
      queued_tasks[tail_idx]   <= in_task;
      queued_threads[tail_idx] <= in_thread;
    end else if (advance && pop) begin
      for (int i = 0; i < WAIT_DEPTH - 1; i++) begin
        queued_tasks[i]   <= queued_tasks[i + 1];
        queued_threads[i] <= queued_threads[i + 1];
      end
    end
  end

  // Result register: hold while stalled, load the fresh result on advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result_word;
    end
  end

endmodule

`default_nettype wire

/* sv/omwq_checker.sv */
// Port-level assertion checker for owned_mutex_with_wait_queue, bound to the top.
// Depends on omwq_pkg and owned_mutex_with_wait_queue_macros.svh.
`default_nettype none
`include "owned_mutex_with_wait_queue_macros.svh"

module omwq_assertions (
  input wire                              clk,
  input wire                              rst,
  input wire                              m_tvalid,
  input wire                              m_tready,
  input wire [omwq_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import omwq_pkg::*;

  logic [STAT_W-1:0]    st;
  logic [WAITERS_W-1:0] waiters;

  assign st      = m_tdata[OFS_STATUS +: STAT_W];
  assign waiters = m_tdata[OFS_WAITERS +: WAITERS_W];

  // Result stage comes out of reset empty.
  `OMWQ_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid)
  // Stalled result word holds.
  `OMWQ_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
  // A woken waiter is only reported by a successful release.
  `OMWQ_ASSERT(a_wake_on_release,
               (m_tvalid && m_tdata[OFS_WVALID]) |-> (st == ST_RELEASED))
  // Lock state agrees with acquire and release.
  `OMWQ_ASSERT(a_locked_state,
               (m_tvalid && (st == ST_ACQUIRED || st == ST_RELEASED))
               |-> (m_tdata[OFS_LOCKED] == (st == ST_ACQUIRED)))
  // Queue never reports more waiters than it has room for.
  `OMWQ_ASSERT(a_waiters_bound,
               m_tvalid |-> (WCNT_W'(waiters) <= WCNT_W'(WAIT_DEPTH)))

endmodule

bind owned_mutex_with_wait_queue omwq_assertions u_omwq_assertions (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
